### rtl/las_pkg.sv
// Shared types, widths and constants of the local alignment score block.
`timescale 1ns / 1ps
package las_pkg;

    // Default number of reference cells in the chain
    localparam int LAS_MAX_LEN   = 64;

    // Score and field widths
    localparam int LAS_SCORE_W   = 14;
    localparam int LAS_SYM_W     = 8;
    localparam int LAS_MATCH_W   = 7;
    localparam int LAS_PEN_W     = 8;
    localparam int LAS_CFG_IDX_W = 2;
    localparam int LAS_CFG_DAT_W = 8;
    localparam int LAS_CALC_W    = 16;
    localparam int LAS_SCORE_MAX = (1 << LAS_SCORE_W) - 1;

    // Register reset values
    localparam logic [LAS_MATCH_W-1:0] LAS_MATCH_RST    = 7'd1;
    localparam logic [LAS_PEN_W-1:0]   LAS_MISMATCH_RST = 8'hFE;  // -2
    localparam logic [LAS_PEN_W-1:0]   LAS_GAP_RST      = 8'hFC;  // -4

    // Register indexes on the configuration port
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [LAS_CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    // Item kinds
    localparam logic KIND_REF    = 1'b0;
    localparam logic KIND_STREAM = 1'b1;

    // Divider: one quotient bit per cycle
    localparam int LAS_DIV_STEPS = LAS_SCORE_W;
    localparam int LAS_DIV_CNT_W = $clog2(LAS_DIV_STEPS);

    // Scoring registers as seen by every cell
    typedef struct packed {
        logic [LAS_MATCH_W-1:0] match_score;
        logic [LAS_PEN_W-1:0]   mismatch_score;
        logic [LAS_PEN_W-1:0]   gap_score;
    } t_cfg;

    // Row token handed from one cell to the next
    typedef struct packed {
        logic                   valid;
        logic [LAS_SYM_W-1:0]   symbol;
        logic                   last;
        logic [LAS_SCORE_W-1:0] h_new;   // left neighbour, this row
        logic [LAS_SCORE_W-1:0] h_old;   // left neighbour, previous row
        logic [LAS_SCORE_W-1:0] best;    // best cell of this row so far
    } t_tok;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

### rtl/las_cell.sv
// One systolic cell: holds a reference byte and its column score.
`timescale 1ns / 1ps
module las_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  las_pkg::t_cfg                    i_cfg,
    input  logic                             i_load,
    input  logic [las_pkg::LAS_SYM_W-1:0]    i_load_sym,
    input  las_pkg::t_tok                    i_tok,
    output las_pkg::t_tok                    o_tok
);
    import las_pkg::*;

    logic                   r_loaded;
    logic [LAS_SYM_W-1:0]   r_ref;
    logic [LAS_SCORE_W-1:0] r_h;
    t_tok                   r_tok;

    logic [LAS_SCORE_W-1:0] n_h;
    t_tok                   n_tok;

    logic signed [LAS_CALC_W-1:0] w_sub;
    logic signed [LAS_CALC_W-1:0] w_gap;
    logic signed [LAS_CALC_W-1:0] w_diag;
    logic signed [LAS_CALC_W-1:0] w_up;
    logic signed [LAS_CALC_W-1:0] w_left;
    logic signed [LAS_CALC_W-1:0] w_max;
    logic [LAS_SCORE_W-1:0]       w_cell;
    logic                         w_calc;

    // Cell score: best of diagonal, up and left, clamped to the score range
    always_comb begin
        w_sub = (r_ref == i_tok.symbol)
              ? $signed({{(LAS_CALC_W-LAS_MATCH_W){1'b0}}, i_cfg.match_score})
              : $signed({{(LAS_CALC_W-LAS_PEN_W){i_cfg.mismatch_score[LAS_PEN_W-1]}},
                         i_cfg.mismatch_score});
        w_gap  = $signed({{(LAS_CALC_W-LAS_PEN_W){i_cfg.gap_score[LAS_PEN_W-1]}},
                          i_cfg.gap_score});
        w_diag = $signed({{(LAS_CALC_W-LAS_SCORE_W){1'b0}}, i_tok.h_old}) + w_sub;
        w_up   = $signed({{(LAS_CALC_W-LAS_SCORE_W){1'b0}}, r_h}) + w_gap;
        w_left = $signed({{(LAS_CALC_W-LAS_SCORE_W){1'b0}}, i_tok.h_new}) + w_gap;
        w_max  = (w_diag > w_up) ? w_diag : w_up;
        w_max  = (w_left > w_max) ? w_left : w_max;
        priority if (w_max < 0) begin
            w_cell = '0;
        end else if (w_max > LAS_CALC_W'(LAS_SCORE_MAX)) begin
            w_cell = LAS_SCORE_W'(LAS_SCORE_MAX);
        end else begin
            w_cell = w_max[LAS_SCORE_W-1:0];
        end
        w_calc = i_tok.valid && r_loaded;
    end

    // Next column score and outgoing token; a last row clears the column
    always_comb begin
        n_h = r_h;
        if (i_tok.valid) begin
            priority if (i_tok.last) begin
                n_h = '0;
            end else if (r_loaded) begin
                n_h = w_cell;
            end else begin
                n_h = r_h;
            end
        end
        n_tok        = i_tok;
        n_tok.h_old  = r_h;
        n_tok.h_new  = w_calc ? w_cell : r_h;
        n_tok.best   = (w_calc && (w_cell > i_tok.best)) ? w_cell : i_tok.best;
    end

    // Control, score and token state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_h      <= '0;
            r_tok    <= '0;
        end else begin
            r_h   <= n_h;
            r_tok <= n_tok;
            if (i_load) begin
                r_loaded <= 1'b1;
            end else if (i_tok.valid && i_tok.last) begin
                r_loaded <= 1'b0;
            end
        end
    end

    // Reference byte
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ref <= i_load_sym;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/las_div.sv
// Restoring divider for best score over match score, one bit per cycle.
`timescale 1ns / 1ps
module las_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [las_pkg::LAS_SCORE_W-1:0]    i_dividend,
    input  logic [las_pkg::LAS_MATCH_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [las_pkg::LAS_SCORE_W-1:0]    o_quot
);
    import las_pkg::*;

    t_div_state               r_state;
    t_div_state               n_state;
    logic [LAS_DIV_CNT_W-1:0] r_cnt;
    logic [LAS_MATCH_W-1:0]   r_rem;
    logic [LAS_SCORE_W-1:0]   r_quot;
    logic [LAS_MATCH_W-1:0]   r_dvs;

    logic [LAS_MATCH_W:0]     w_trial;
    logic [LAS_MATCH_W:0]     w_diff;
    logic                     w_ge;
    logic                     w_last_step;

    // One trial subtraction per cycle
    assign w_trial     = {r_rem, r_quot[LAS_SCORE_W-1]};
    assign w_diff      = w_trial - {1'b0, r_dvs};
    assign w_ge        = (w_trial >= {1'b0, r_dvs});
    assign w_last_step = (r_cnt == LAS_DIV_CNT_W'(LAS_DIV_STEPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (w_last_step) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = (r_state == DIV_DONE);
        o_quot = r_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == DIV_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Datapath; a zero divisor divides by one
    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= (i_divisor == '0) ? LAS_MATCH_W'(1) : i_divisor;
        end else if (r_state == DIV_RUN) begin
            r_quot <= {r_quot[LAS_SCORE_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[LAS_MATCH_W-1:0] : w_trial[LAS_MATCH_W-1:0];
        end
    end

endmodule

### rtl/local_alignment_score.sv
// Top level: Smith-Waterman local alignment score over a systolic row of cells.
`timescale 1ns / 1ps
// Kind 0 items load the reference string, one byte per cell, up to MAX_LEN bytes
// (further bytes are dropped and reported as overflow). Kind 1 items stream the
// second string and are taken one per cycle unless a last-marked byte is held off:
// each byte enters the row of MAX_LEN cells and moves one cell per cycle. A kind 0
// item is held off while any streamed byte is still in the row. The byte marked
// last produces one result after passing through the row, the 14 steps of the
// restoring divider that forms best_score / match_score and the load of the result
// register. A further last-marked byte waits until the previous result has been
// taken. A last-marked byte clears the reference string, scores and overflow flag;
// configuration registers are kept.
module local_alignment_score #(
    parameter int MAX_LEN = las_pkg::LAS_MAX_LEN
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [las_pkg::LAS_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [las_pkg::LAS_CFG_DAT_W-1:0]    i_cfg_data,
    // input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic [las_pkg::LAS_SYM_W-1:0]        i_symbol,
    input  logic                                 i_last,
    // result items
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [las_pkg::LAS_SCORE_W-1:0]      o_best_score,
    output logic [las_pkg::LAS_SCORE_W-1:0]      o_match_units,
    output logic                                 o_overflow
);
    import las_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);

    t_cfg                   r_cfg;
    logic [LW-1:0]          r_len;
    logic                   r_drop;
    logic [LAS_SCORE_W-1:0] r_best;
    logic                   r_res_busy;
    logic                   r_res_drop;
    logic [LAS_SCORE_W-1:0] r_res_best;
    logic                   r_out_valid;
    logic [LAS_SCORE_W-1:0] r_out_best;
    logic [LAS_SCORE_W-1:0] r_out_units;
    logic                   r_out_drop;

    logic [LAS_SCORE_W-1:0] n_best;

    t_tok                   c_tok [MAX_LEN+1];
    logic [MAX_LEN-1:0]     w_tok_vec;
    logic [MAX_LEN-1:0]     w_last_vec;
    logic                   w_busy;
    logic                   w_in_acc;
    logic                   w_ref_acc;
    logic                   w_str_acc;
    logic                   w_full;
    t_tok                   w_exit;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [LAS_SCORE_W-1:0] w_div_quot;
    logic                   w_out_acc;

    // Input handshake
    assign w_busy     = |w_tok_vec;
    assign o_in_stall = ((i_kind == KIND_REF) && w_busy)
                     || ((i_kind == KIND_STREAM) && i_last && r_res_busy);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_ref_acc  = w_in_acc && (i_kind == KIND_REF);
    assign w_str_acc  = w_in_acc && (i_kind == KIND_STREAM);
    assign w_full     = (r_len == LW'(MAX_LEN));

    // Row token entering the first cell; the left border is zero
    always_comb begin
        c_tok[0]        = '0;
        c_tok[0].valid  = w_str_acc;
        c_tok[0].symbol = i_symbol;
        c_tok[0].last   = i_last;
    end

    // Chain of cells
    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        las_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg      (r_cfg),
            .i_load     (w_ref_acc && (r_len == LW'(j))),
            .i_load_sym (i_symbol),
            .i_tok      (c_tok[j]),
            .o_tok      (c_tok[j+1])
        );
        assign w_tok_vec[j]  = c_tok[j+1].valid;
        assign w_last_vec[j] = c_tok[j+1].valid && c_tok[j+1].last;
    end

    // Token leaving the row: fold its row maximum into the running best
    assign w_exit      = c_tok[MAX_LEN];
    assign w_div_start = w_exit.valid && w_exit.last;
    always_comb begin
        n_best = r_best;
        if (w_exit.valid && (w_exit.best > r_best)) begin
            n_best = w_exit.best;
        end
    end

    las_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_best),
        .i_divisor  (r_cfg.match_score),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign w_out_acc = r_out_valid && !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_score    <= LAS_MATCH_RST;
            r_cfg.mismatch_score <= LAS_MISMATCH_RST;
            r_cfg.gap_score      <= LAS_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH:    r_cfg.match_score    <= i_cfg_data[LAS_MATCH_W-1:0];
                CFG_MISMATCH: r_cfg.mismatch_score <= i_cfg_data[LAS_PEN_W-1:0];
                CFG_GAP:      r_cfg.gap_score      <= i_cfg_data[LAS_PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Reference length, overflow flag, best score and result bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_drop      <= 1'b0;
            r_best      <= '0;
            r_res_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ref_acc) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_len <= r_len + 1'b1;
                end
            end else if (w_str_acc && i_last) begin
                r_len  <= '0;
                r_drop <= 1'b0;
            end

            r_best <= w_div_start ? '0 : n_best;

            if (w_str_acc && i_last) begin
                r_res_busy <= 1'b1;
            end else if (w_out_acc) begin
                r_res_busy <= 1'b0;
            end

            if (w_div_done) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_str_acc && i_last) begin
            r_res_drop <= r_drop;
        end
        if (w_div_start) begin
            r_res_best <= n_best;
        end
        if (w_div_done) begin
            r_out_best  <= r_res_best;
            r_out_units <= w_div_quot;
            r_out_drop  <= r_res_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_best_score  = r_out_best;
    assign o_match_units = r_out_units;
    assign o_overflow    = r_out_drop;

    // Checks
    a_one_last_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_last_vec) <= 1)
        else $error("more than one last-marked row in the cell chain");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("reference length beyond the cell count");

    a_div_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_res_busy && !r_out_valid))
        else $error("divider finished with no free result slot");

    a_exit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_res_busy && !r_out_valid))
        else $error("last row left the chain with no result pending");

endmodule
